### rtl/core/i2csbs_pkg.sv
package i2csbs_pkg;

	localparam int RX_DEPTH = 2;
	localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
	localparam logic [RX_CNT_W-1:0] RX_FULL = RX_CNT_W'(RX_DEPTH);

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPLY_BYTE = 1'd1;

	typedef enum logic [5:0] {
		PH_CHECK_ADDR  = 6'b000001,
		PH_SEND_DATA   = 6'b000010,
		PH_REQ_REPLY   = 6'b000100,
		PH_CHECK_REPLY = 6'b001000,
		PH_REQ_DATA    = 6'b010000,
		PH_GET_DATA    = 6'b100000
	} phase_t;

	typedef struct packed {
		logic       drive_sda;
		logic       load_valid;
		logic [7:0] load_byte;
		logic       shift_one_bit;
		logic       listening;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_slot;
	} result_t;

endpackage

### rtl/core/i2c_slave_byte_sequencer.sv
// Byte-level sequencer of an I2C slave.
// Input channel (in_valid/in_ready): one beat per bus event, either a start
// condition (action 0, with stop_followed) or a shift counter overflow
// (action 1, with shifted_byte, ack bit in bit 0).
// Output channel (out_valid/out_ready): one beat per input beat, telling the
// shifter whether to drive SDA, what to load, whether the next shift is one
// or eight bits and whether overflows are still handled; rx_valid marks a
// received write byte stored into slot rx_slot.
// Configuration: cfg_we writes own_address (index 0) or reply_byte (index 1)
// from cfg_data; write only while no beat is in flight.
// Path: an input beat is held in the input register, and its result is
// registered in the output register as the beat moves on from there.
// Throughput: one beat per cycle while out_ready is high; the sequencer state
// is updated as a beat moves from the input register to the output register.
// Reset: the block waits for a start condition, the phase is address check,
// the receive count and both configuration registers are zero.
// Stall: when out_ready is low the output register holds its beat, the input
// register fills, and in_ready drops until the output beat is taken.
module i2c_slave_byte_sequencer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [i2csbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [i2csbs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 action,
	input  logic                                 stop_followed,
	input  logic [7:0]                           shifted_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 drive_sda,
	output logic                                 load_valid,
	output logic [7:0]                           load_byte,
	output logic                                 shift_one_bit,
	output logic                                 listening,
	output logic                                 rx_valid,
	output logic [7:0]                           rx_byte,
	output logic                                 rx_slot
);

	logic [6:0] own_address_q;
	logic [7:0] reply_byte_q;

	i2csbs_pkg::phase_t                  phase_q, phase_d;
	logic                                active_q, active_d;
	logic [i2csbs_pkg::RX_CNT_W-1:0]     rx_count_q, rx_count_d;

	logic       v_s1;
	logic       action_s1;
	logic       stop_followed_s1;
	logic [7:0] shifted_byte_s1;

	logic                v_s2;
	i2csbs_pkg::result_t res_s2, res_d;

	logic adv_s2;
	logic adv_s1;
	logic ack_out;
	logic go_idle;

	assign adv_s2   = !v_s2 || out_ready;
	assign adv_s1   = v_s1 && adv_s2;
	assign in_ready = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
			reply_byte_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2csbs_pkg::REG_OWN_ADDRESS: own_address_q <= cfg_data[6:0];
				i2csbs_pkg::REG_REPLY_BYTE:  reply_byte_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1        <= action;
			stop_followed_s1 <= stop_followed;
			shifted_byte_s1  <= shifted_byte;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		active_d   = active_q;
		rx_count_d = rx_count_q;
		res_d      = '0;
		ack_out    = 1'b0;
		go_idle    = 1'b0;
		if (!action_s1) begin
			phase_d    = i2csbs_pkg::PH_CHECK_ADDR;
			active_d   = !stop_followed_s1;
			rx_count_d = '0;
		end else if (active_q) begin
			unique case (phase_q)
				i2csbs_pkg::PH_CHECK_ADDR: begin
					if (shifted_byte_s1[7:1] == own_address_q) begin
						phase_d = shifted_byte_s1[0] ? i2csbs_pkg::PH_SEND_DATA
							: i2csbs_pkg::PH_REQ_DATA;
						ack_out = 1'b1;
					end else begin
						go_idle = 1'b1;
					end
				end
				i2csbs_pkg::PH_SEND_DATA, i2csbs_pkg::PH_CHECK_REPLY: begin
					if (phase_q == i2csbs_pkg::PH_CHECK_REPLY && shifted_byte_s1 != 8'h00) begin
						go_idle = 1'b1;
					end else begin
						res_d.drive_sda  = 1'b1;
						res_d.load_valid = 1'b1;
						res_d.load_byte  = reply_byte_q;
						phase_d          = i2csbs_pkg::PH_REQ_REPLY;
					end
				end
				i2csbs_pkg::PH_REQ_REPLY: begin
					phase_d             = i2csbs_pkg::PH_CHECK_REPLY;
					res_d.load_valid    = 1'b1;
					res_d.shift_one_bit = 1'b1;
				end
				i2csbs_pkg::PH_REQ_DATA: begin
					phase_d = i2csbs_pkg::PH_GET_DATA;
				end
				i2csbs_pkg::PH_GET_DATA: begin
					if (rx_count_q < i2csbs_pkg::RX_FULL) begin
						res_d.rx_valid = 1'b1;
						res_d.rx_byte  = shifted_byte_s1;
						res_d.rx_slot  = rx_count_q[0];
						rx_count_d     = rx_count_q + 1'b1;
					end
					phase_d = i2csbs_pkg::PH_REQ_DATA;
					ack_out = 1'b1;
				end
				default: begin
					go_idle = 1'b1;
				end
			endcase
			if (ack_out) begin
				res_d.drive_sda     = 1'b1;
				res_d.load_valid    = 1'b1;
				res_d.load_byte     = 8'h00;
				res_d.shift_one_bit = 1'b1;
			end
			if (go_idle) begin
				active_d            = 1'b0;
				res_d.drive_sda     = 1'b0;
				res_d.load_valid    = 1'b0;
				res_d.load_byte     = 8'h00;
				res_d.shift_one_bit = 1'b0;
			end
		end
		res_d.listening = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= i2csbs_pkg::PH_CHECK_ADDR;
			active_q   <= 1'b0;
			rx_count_q <= '0;
			v_s2       <= 1'b0;
		end else begin
			if (adv_s1) begin
				phase_q    <= phase_d;
				active_q   <= active_d;
				rx_count_q <= rx_count_d;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = v_s2;
	assign drive_sda     = res_s2.drive_sda;
	assign load_valid    = res_s2.load_valid;
	assign load_byte     = res_s2.load_byte;
	assign shift_one_bit = res_s2.shift_one_bit;
	assign listening     = res_s2.listening;
	assign rx_valid      = res_s2.rx_valid;
	assign rx_byte       = res_s2.rx_byte;
	assign rx_slot       = res_s2.rx_slot;

	a_drive_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_sda |-> load_valid)
		else $error("SDA driven without a load");

	a_load_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !load_valid |-> load_byte == 8'h00)
		else $error("load byte set without a load");

	a_rx_while_listening: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_valid |-> listening)
		else $error("byte stored while not listening");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !listening |-> !drive_sda && !rx_valid && !shift_one_bit)
		else $error("idle result not quiet");

	a_rx_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= i2csbs_pkg::RX_FULL)
		else $error("receive count beyond buffer depth");

endmodule

### dv/i2c_slave_byte_sequencer_tb.sv
`timescale 1ns / 1ps

module i2c_slave_byte_sequencer_tb;

	localparam int STALL_LIMIT = 20000;

	class seq_scoreboard;
		i2csbs_pkg::phase_t  ph;
		bit                  active;
		int                  rx_count;
		logic [6:0]          own_addr;
		logic [7:0]          reply;
		i2csbs_pkg::result_t expected_q[$];
		int                  errors;

		function new();
			ph = i2csbs_pkg::PH_CHECK_ADDR;
			active = 1'b0;
			rx_count = 0;
			own_addr = '0;
			reply = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [i2csbs_pkg::CFG_IDX_W-1:0] idx,
			logic [i2csbs_pkg::CFG_DATA_W-1:0] data);
			if (idx == i2csbs_pkg::REG_OWN_ADDRESS)
				own_addr = data[6:0];
			else if (idx == i2csbs_pkg::REG_REPLY_BYTE)
				reply = data;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function i2csbs_pkg::result_t sequence_event(bit act, bit stopf, logic [7:0] b);
			i2csbs_pkg::result_t r;
			bit ack_out;
			bit go_idle;
			r = '0;
			ack_out = 1'b0;
			go_idle = 1'b0;
			if (!act) begin
				ph = i2csbs_pkg::PH_CHECK_ADDR;
				active = !stopf;
				rx_count = 0;
			end else if (active) begin
				case (ph)
					i2csbs_pkg::PH_CHECK_ADDR: begin
						if (b[7:1] == own_addr) begin
							ph = b[0] ? i2csbs_pkg::PH_SEND_DATA : i2csbs_pkg::PH_REQ_DATA;
							ack_out = 1'b1;
						end else begin
							go_idle = 1'b1;
						end
					end
					i2csbs_pkg::PH_SEND_DATA, i2csbs_pkg::PH_CHECK_REPLY: begin
						if (ph == i2csbs_pkg::PH_CHECK_REPLY && b != 8'h00) begin
							go_idle = 1'b1;
						end else begin
							r.drive_sda = 1'b1;
							r.load_valid = 1'b1;
							r.load_byte = reply;
							ph = i2csbs_pkg::PH_REQ_REPLY;
						end
					end
					i2csbs_pkg::PH_REQ_REPLY: begin
						ph = i2csbs_pkg::PH_CHECK_REPLY;
						r.load_valid = 1'b1;
						r.shift_one_bit = 1'b1;
					end
					i2csbs_pkg::PH_REQ_DATA: ph = i2csbs_pkg::PH_GET_DATA;
					i2csbs_pkg::PH_GET_DATA: begin
						if (rx_count < i2csbs_pkg::RX_DEPTH) begin
							r.rx_valid = 1'b1;
							r.rx_byte = b;
							r.rx_slot = rx_count[0];
							rx_count++;
						end
						ph = i2csbs_pkg::PH_REQ_DATA;
						ack_out = 1'b1;
					end
					default: go_idle = 1'b1;
				endcase
				if (ack_out) begin
					r.drive_sda = 1'b1;
					r.load_valid = 1'b1;
					r.load_byte = 8'h00;
					r.shift_one_bit = 1'b1;
				end
				if (go_idle) begin
					active = 1'b0;
					r.drive_sda = 1'b0;
					r.load_valid = 1'b0;
					r.load_byte = 8'h00;
					r.shift_one_bit = 1'b0;
				end
			end
			r.listening = active;
			return r;
		endfunction

		function void note_event(bit act, bit stopf, logic [7:0] b);
			expected_q.push_back(sequence_event(act, stopf, b));
		endfunction

		task report(string msg);
			errors++;
			$display("%0t MISMATCH: %s", $realtime, msg);
		endtask

		task cmp_field(string name, int got, int exp);
			if (got != exp)
				report($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
		endtask

		task check_result(i2csbs_pkg::result_t got);
			i2csbs_pkg::result_t exp;
			if (expected_q.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			exp = expected_q.pop_front();
			cmp_field("drive_sda", got.drive_sda, exp.drive_sda);
			cmp_field("load_valid", got.load_valid, exp.load_valid);
			cmp_field("load_byte", got.load_byte, exp.load_byte);
			cmp_field("shift_one_bit", got.shift_one_bit, exp.shift_one_bit);
			cmp_field("listening", got.listening, exp.listening);
			cmp_field("rx_valid", got.rx_valid, exp.rx_valid);
			cmp_field("rx_byte", got.rx_byte, exp.rx_byte);
			cmp_field("rx_slot", got.rx_slot, exp.rx_slot);
		endtask
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [i2csbs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [i2csbs_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                              in_valid;
	logic                              in_ready;
	logic                              action;
	logic                              stop_followed;
	logic [7:0]                        shifted_byte;
	logic                              out_valid;
	logic                              out_ready;
	logic                              drive_sda;
	logic                              load_valid;
	logic [7:0]                        load_byte;
	logic                              shift_one_bit;
	logic                              listening;
	logic                              rx_valid;
	logic [7:0]                        rx_byte;
	logic                              rx_slot;

	seq_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int sent_beats;

	i2c_slave_byte_sequencer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.stop_followed (stop_followed),
		.shifted_byte  (shifted_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_sda     (drive_sda),
		.load_valid    (load_valid),
		.load_byte     (load_byte),
		.shift_one_bit (shift_one_bit),
		.listening     (listening),
		.rx_valid      (rx_valid),
		.rx_byte       (rx_byte),
		.rx_slot       (rx_slot)
	);

	always #5 clk = ~clk;

	task automatic send_beat(input bit act, input bit stopf, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		stop_followed <= stopf;
		shifted_byte <= b;
		do @(posedge clk); while (!in_ready);
		sent_beats++;
		sb.note_event(act, stopf, b);
	endtask

	task automatic write_config(input logic [6:0] own, input logic [7:0] reply);
		cfg_we <= 1'b1;
		cfg_index <= i2csbs_pkg::REG_OWN_ADDRESS;
		cfg_data <= {1'b0, own};
		@(posedge clk);
		sb.set_reg(i2csbs_pkg::REG_OWN_ADDRESS, {1'b0, own});
		cfg_index <= i2csbs_pkg::REG_REPLY_BYTE;
		cfg_data <= reply;
		@(posedge clk);
		sb.set_reg(i2csbs_pkg::REG_REPLY_BYTE, reply);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_directed();
		send_beat(1'b1, 1'b0, 8'hFF);
		send_beat(1'b0, 1'b1, 8'h00);
		send_beat(1'b1, 1'b1, 8'h00);
		send_beat(1'b0, 1'b0, 8'hFF);
		send_beat(1'b1, 1'b0, 8'hFF);
		send_beat(1'b1, 1'b0, 8'h00);
		send_beat(1'b0, 1'b0, 8'h00);
		send_beat(1'b1, 1'b0, 8'h00);
		send_beat(1'b1, 1'b0, 8'hFF);
		send_beat(1'b1, 1'b0, 8'hA5);
		send_beat(1'b1, 1'b0, 8'h00);
		send_beat(1'b1, 1'b1, 8'hFF);
		send_beat(1'b1, 1'b0, 8'h01);
		send_beat(1'b1, 1'b0, 8'h5A);
		send_beat(1'b0, 1'b0, 8'h7E);
		send_beat(1'b1, 1'b0, 8'h01);
		send_beat(1'b1, 1'b0, 8'h00);
		send_beat(1'b1, 1'b0, 8'hFF);
		send_beat(1'b1, 1'b0, 8'h00);
		send_beat(1'b1, 1'b0, 8'h3C);
		send_beat(1'b1, 1'b0, 8'h80);
		send_beat(1'b1, 1'b0, 8'h00);
		send_beat(1'b0, 1'b1, 8'h81);
	endtask

	task automatic run_transfer(input logic [6:0] own);
		bit         rd;
		int         n;
		logic [7:0] addr;
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 3))
				send_beat(1'($urandom_range(1)), 1'($urandom_range(1)),
					8'($urandom_range(255)));
			return;
		end
		rd = 1'($urandom_range(1));
		addr = ($urandom_range(9) < 8) ? {own, rd} : 8'($urandom_range(255));
		n = $urandom_range(0, 4);
		send_beat(1'b0, $urandom_range(9) == 0, 8'($urandom_range(255)));
		send_beat(1'b1, 1'($urandom_range(1)), addr);
		if (!rd) begin
			repeat (n) begin
				send_beat(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
				send_beat(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
			end
		end else begin
			send_beat(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
			repeat (n) begin
				send_beat(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
				send_beat(1'b1, 1'($urandom_range(1)), 8'h00);
			end
			if ($urandom_range(3) != 0) begin
				send_beat(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
				send_beat(1'b1, 1'($urandom_range(1)), 8'($urandom_range(1, 255)));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = 1'b0;
		stop_followed = 1'b0;
		shifted_byte = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sent_beats = 0;
		sb = new();
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result({drive_sda, load_valid, load_byte, shift_one_bit,
					listening, rx_valid, rx_byte, rx_slot});
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [6:0] own;
		logic [7:0] reply;
		int         phase_start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					send_idle_pct = 33;
					recv_idle_pct = 49;
				end
				1: begin
					send_idle_pct = 49;
					recv_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			own = (p == 0) ? 7'h00 : (p == 1) ? 7'h7F : 7'($urandom_range(127));
			reply = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(255));
			write_config(own, reply);
			if (p == 0)
				run_directed();
			phase_start = sent_beats;
			while (sent_beats - phase_start < 150)
				run_transfer(own);
			in_valid <= 1'b0;
			drain();
		end
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
